// File: rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants of the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int STACK_DEPTH     = 64;
   localparam int VALUE_WIDTH     = 32;
   localparam int DATA_WIDTH      = 32;
   localparam int COUNT_OUT_WIDTH = 7;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_POP_EMPTY  = 2'd1,
      STS_PUSH_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE     = 2'b01,
      S_POP_WAIT = 2'b10
   } state_type;

endpackage

// File: rtl/core/mts_req_if.sv
// ----------------------------------------------------------------------------
// mts_req_if
// Request channel: push or pop with the value to push.
// ----------------------------------------------------------------------------
interface mts_req_if;
   logic                                   valid;
   logic                                   ready;
   mts_pkg::op_type                        operation;
   logic signed [mts_pkg::DATA_WIDTH-1:0]  push_value;

   modport source (output valid, output operation, output push_value, input ready);
   modport sink   (input valid, input operation, input push_value, output ready);
endinterface

// File: rtl/core/mts_rsp_if.sv
// ----------------------------------------------------------------------------
// mts_rsp_if
// Response channel: top, minimum, count and status after each operation.
// ----------------------------------------------------------------------------
interface mts_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [mts_pkg::DATA_WIDTH-1:0]    top_value;
   logic signed [mts_pkg::DATA_WIDTH-1:0]    min_value;
   logic [mts_pkg::COUNT_OUT_WIDTH-1:0]      element_count;
   logic                                     is_empty;
   mts_pkg::status_type                      status;

   modport source (output valid, output top_value, output min_value, output element_count,
                   output is_empty, output status, input ready);
   modport sink   (input valid, input top_value, input min_value, input element_count,
                   input is_empty, input status, output ready);
endinterface

// File: rtl/core/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded stack with running minimum; top and minimum cached in registers.
// ----------------------------------------------------------------------------
// Push, ignored pop and ignored push: the response is registered directly on transfer.
// Pop of a stored value: registered RAM read, then S_POP_WAIT, then the registered response.
// Throughput: one push per cycle while the response is taken; a pop blocks requests in S_POP_WAIT.
// Reset clears counts, state and response valid; RAM contents are not cleared,
// entries at or above the counts never reach the outputs.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH,
   parameter int VALUE_WIDTH = mts_pkg::VALUE_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   mts_req_if.sink   req_bus,
   mts_rsp_if.source rsp_bus
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   mts_pkg::state_type       state_ff, state_in;
   logic [CW-1:0]            vcount_ff, vcount_in;
   logic [CW-1:0]            mcount_ff, mcount_in;
   logic signed [VALUE_WIDTH-1:0] top_ff, top_in;
   logic signed [VALUE_WIDTH-1:0] min_ff, min_in;
   logic                     drop_ff, drop_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mts_pkg::status_type      status_ff, status_in;

   logic                     accept;
   logic signed [VALUE_WIDTH-1:0] push_val;
   logic                     full;
   logic                     new_min;
   logic                     vwr_en, mwr_en;
   logic [AW-1:0]            vrd_idx, mrd_idx;
   logic [VALUE_WIDTH-1:0]   vrd_data, mrd_data;

   assign push_val       = VALUE_WIDTH'(req_bus.push_value);
   assign full           = (vcount_ff == CW'(STACK_DEPTH));
   assign new_min        = (mcount_ff == '0) || (push_val <= min_ff);
   assign req_bus.ready  = (state_ff == mts_pkg::S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept         = req_bus.valid && req_bus.ready;

   // entries just below the top of each stack, used after a pop
   assign vrd_idx = vcount_ff[AW-1:0] - AW'(2);
   assign mrd_idx = mcount_ff[AW-1:0] - AW'(2);

   assign vwr_en = accept && (req_bus.operation == mts_pkg::OP_PUSH) && !full;
   assign mwr_en = vwr_en && new_min;

   mts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(VALUE_WIDTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (vwr_en),
      .wr_addr (vcount_ff[AW-1:0]),
      .wr_data (push_val),
      .rd_addr (vrd_idx),
      .rd_data (vrd_data)
   );

   mts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(VALUE_WIDTH)) u_min_ram (
      .clock   (clock),
      .wr_en   (mwr_en),
      .wr_addr (mcount_ff[AW-1:0]),
      .wr_data (push_val),
      .rd_addr (mrd_idx),
      .rd_data (mrd_data)
   );

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      mcount_in    = mcount_ff;
      top_in       = top_ff;
      min_in       = min_ff;
      drop_in      = drop_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      case (state_ff)
         mts_pkg::S_IDLE: begin
            if (accept) begin
               if (req_bus.operation == mts_pkg::OP_PUSH) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     status_in = mts_pkg::STS_PUSH_FULL;
                  end else begin
                     status_in = mts_pkg::STS_OK;
                     top_in    = push_val;
                     vcount_in = vcount_ff + CW'(1);
                     if (new_min) begin
                        min_in    = push_val;
                        mcount_in = mcount_ff + CW'(1);
                     end
                  end
               end else if (vcount_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  status_in    = mts_pkg::STS_POP_EMPTY;
               end else begin
                  // new top, and the new minimum if one is dropped, come back from the RAMs next cycle
                  status_in = mts_pkg::STS_OK;
                  drop_in   = (mcount_ff != '0) && (min_ff == top_ff);
                  vcount_in = vcount_ff - CW'(1);
                  if ((mcount_ff != '0) && (min_ff == top_ff)) begin
                     mcount_in = mcount_ff - CW'(1);
                  end
                  state_in = mts_pkg::S_POP_WAIT;
               end
            end
         end
         mts_pkg::S_POP_WAIT: begin
            top_in = vrd_data;
            if (drop_ff) begin
               min_in = mrd_data;
            end
            rsp_valid_in = 1'b1;
            state_in     = mts_pkg::S_IDLE;
         end
         default: begin
            state_in = mts_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mts_pkg::S_IDLE;
         vcount_ff    <= '0;
         mcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         mcount_ff    <= mcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      min_ff    <= min_in;
      drop_ff   <= drop_in;
      status_ff <= status_in;
   end

   // response payload is held stable: state only moves on a new transfer
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.top_value     = (vcount_ff == '0) ? '0 : mts_pkg::DATA_WIDTH'(top_ff);
   assign rsp_bus.min_value     = (mcount_ff == '0) ? '0 : mts_pkg::DATA_WIDTH'(min_ff);
   assign rsp_bus.element_count = mts_pkg::COUNT_OUT_WIDTH'(vcount_ff);
   assign rsp_bus.is_empty      = (vcount_ff == '0);
   assign rsp_bus.status        = status_ff;

   a_min_le_count: assert property (@(posedge clock) disable iff (reset)
      mcount_ff <= vcount_ff)
      else $error("minimum stack deeper than value stack");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= CW'(STACK_DEPTH))
      else $error("value count beyond depth");

   a_wait_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == mts_pkg::S_POP_WAIT |=> state_ff == mts_pkg::S_IDLE && rsp_valid_ff)
      else $error("pop wait did not complete with a response");

   a_wait_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == mts_pkg::S_POP_WAIT |-> !rsp_valid_ff && !req_bus.ready)
      else $error("pop wait overlaps a response or a request transfer");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.operation == mts_pkg::OP_POP && vcount_ff != '0
      |=> vcount_ff == $past(vcount_ff) - CW'(1))
      else $error("pop did not decrement count");

endmodule

// File: rtl/core/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mts_ram #(
   parameter int DEPTH = mts_pkg::STACK_DEPTH,
   parameter int WIDTH = mts_pkg::VALUE_WIDTH,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for min_tracking_stack. A directed table (empty and
// full stacks, extreme values, repeated minima) runs first, followed by
// random push/pop phases of varying bias. Each response is checked against a
// pinned table result or a behavioural stack model with its own minimum tracking.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_ITEMS = 1350;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 8;

   localparam logic signed [mts_pkg::DATA_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [mts_pkg::DATA_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [mts_pkg::DATA_WIDTH-1:0] top;
      logic signed [mts_pkg::DATA_WIDTH-1:0] minimum;
      logic [mts_pkg::COUNT_OUT_WIDTH-1:0]   count;
      logic                                  empty;
      mts_pkg::status_type                   status;
   } stack_result_type;

   typedef struct packed {
      bit               fixed;
      stack_result_type want;
   } pinned_type;

   typedef struct {
      mts_pkg::op_type                       op;
      logic signed [mts_pkg::DATA_WIDTH-1:0] value;
      int                                    reps;
      bit                                    rand_value;
      bit                                    fixed;
      stack_result_type                      want;
   } stim_row_type;

   typedef enum int {
      RX_STEADY,
      RX_PATTERN,
      RX_RANDOM
   } rx_mode_type;

   logic clock;
   logic reset;

   mts_req_if req_bus ();
   mts_rsp_if rsp_bus ();

   min_tracking_stack uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Model state; VALUE_WIDTH equals the bus width, so values are held as-is
   logic signed [mts_pkg::VALUE_WIDTH-1:0] model_values [mts_pkg::STACK_DEPTH];
   logic signed [mts_pkg::VALUE_WIDTH-1:0] model_minima [mts_pkg::STACK_DEPTH];
   int                                     model_count;
   int                                     model_min_count;

   stack_result_type expected_results [$];
   pinned_type       pinned_results [$];
   int               error_count;
   int               burst_left;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic stack_result_type apply_stack_op(
         mts_pkg::op_type op, logic signed [mts_pkg::DATA_WIDTH-1:0] val);
      stack_result_type                       r;
      logic signed [mts_pkg::VALUE_WIDTH-1:0] popped;
      r.status = mts_pkg::STS_OK;
      if (op == mts_pkg::OP_POP) begin
         if (model_count == 0) begin
            r.status = mts_pkg::STS_POP_EMPTY;
         end else begin
            popped = model_values[model_count-1];
            if (model_min_count > 0 && model_minima[model_min_count-1] == popped)
               model_min_count--;
            model_count--;
         end
      end else begin
         if (model_count >= mts_pkg::STACK_DEPTH) begin
            r.status = mts_pkg::STS_PUSH_FULL;
         end else begin
            model_values[model_count] = val;
            model_count++;
            // equal values are tracked again so a duplicate pop keeps the minimum
            if (model_min_count == 0 || val <= model_minima[model_min_count-1]) begin
               model_minima[model_min_count] = val;
               model_min_count++;
            end
         end
      end
      r.top     = (model_count != 0) ? model_values[model_count-1] : '0;
      r.minimum = (model_min_count != 0) ? model_minima[model_min_count-1] : '0;
      r.count   = model_count[mts_pkg::COUNT_OUT_WIDTH-1:0];
      r.empty   = (model_count == 0);
      return r;
   endfunction

   function automatic stack_result_type res(logic signed [mts_pkg::DATA_WIDTH-1:0] top,
                                            logic signed [mts_pkg::DATA_WIDTH-1:0] minimum,
                                            int count, bit empty,
                                            mts_pkg::status_type status);
      stack_result_type r;
      r.top     = top;
      r.minimum = minimum;
      r.count   = count[mts_pkg::COUNT_OUT_WIDTH-1:0];
      r.empty   = empty;
      r.status  = status;
      return r;
   endfunction

   function automatic logic signed [mts_pkg::DATA_WIDTH-1:0] draw_push_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
         5:       return VAL_MIN + $signed($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   // One item per call; returns at the edge of its transfer with valid still high
   task automatic send_item(mts_pkg::op_type op, logic signed [mts_pkg::DATA_WIDTH-1:0] val,
                            bit fixed, stack_result_type want);
      int         gap;
      pinned_type pin;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      pin.fixed = fixed;
      pin.want  = want;
      pinned_results.insert(pinned_results.size(), pin);
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.push_value <= val;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   always @(posedge clock) begin : bus_monitor
      stack_result_type got;
      stack_result_type want;
      stack_result_type predicted;
      pinned_type       pin;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.top     = rsp_bus.top_value;
            got.minimum = rsp_bus.min_value;
            got.count   = rsp_bus.element_count;
            got.empty   = rsp_bus.is_empty;
            got.status  = rsp_bus.status;
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%t unexpected response: top=%0d min=%0d count=%0d %s%0d %s%0d",
                           $time, got.top, got.minimum, got.count,
                           "empty=", got.empty, "status=", got.status);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%t mismatch: top=%0d min=%0d count=%0d empty=%0d status=%0d",
                              $time, got.top, got.minimum, got.count, got.empty, got.status);
                     $display("   expected: top=%0d min=%0d count=%0d empty=%0d status=%0d",
                              want.top, want.minimum, want.count, want.empty, want.status);
                  end
               end
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            predicted = apply_stack_op(req_bus.operation, req_bus.push_value);
            pin.fixed = 1'b0;
            if (pinned_results.size() != 0)
               pin = pinned_results.pop_front();
            expected_results.insert(expected_results.size(),
                                    pin.fixed ? pin.want : predicted);
         end
      end
   end

   initial begin : receiver
      rx_mode_type mode;
      int          mode_left;
      logic [7:0]  mask;
      int          pos;
      mode      = RX_STEADY;
      mode_left = 0;
      mask      = 8'hFF;
      pos       = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(32, 256);
            mask      = 8'($urandom_range(1, 255));
         end
         mode_left--;
         case (mode)
            RX_STEADY: begin
               rsp_bus.ready <= 1'b1;
            end
            RX_PATTERN: begin
               rsp_bus.ready <= mask[pos];
               pos = (pos + 1) % 8;
            end
            default: begin
               rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            end
         endcase
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle = 0;
         else
            idle++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      stim_row_type    rows [$];
      int              push_mix [5];
      int              sent;
      int              phase;
      int              phase_len;
      int              push_pct;
      mts_pkg::op_type op;

      push_mix        = '{10, 35, 50, 65, 90};
      model_count     = 0;
      model_min_count = 0;
      error_count     = 0;
      burst_left      = 0;

      req_bus.valid      <= 1'b0;
      req_bus.operation  <= mts_pkg::OP_PUSH;
      req_bus.push_value <= '0;
      reset              <= 1'b1;

      // pop on an empty stack straight after reset
      rows.insert(rows.size(), '{mts_pkg::OP_POP, '0, 1, 0, 1,
                                 res('0, '0, 0, 1, mts_pkg::STS_POP_EMPTY)});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, VAL_MAX, 1, 0, 1,
                                 res(VAL_MAX, VAL_MAX, 1, 0, mts_pkg::STS_OK)});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, VAL_MIN, 1, 0, 1,
                                 res(VAL_MIN, VAL_MIN, 2, 0, mts_pkg::STS_OK)});
      // repeated minimum goes on the minimum stack again
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, VAL_MIN, 1, 0, 1,
                                 res(VAL_MIN, VAL_MIN, 3, 0, mts_pkg::STS_OK)});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, '0, 1, 0, 1,
                                 res('0, VAL_MIN, 4, 0, mts_pkg::STS_OK)});
      rows.insert(rows.size(), '{mts_pkg::OP_POP, '0, 1, 0, 1,
                                 res(VAL_MIN, VAL_MIN, 3, 0, mts_pkg::STS_OK)});
      rows.insert(rows.size(), '{mts_pkg::OP_POP, '0, 1, 0, 1,
                                 res(VAL_MIN, VAL_MIN, 2, 0, mts_pkg::STS_OK)});
      rows.insert(rows.size(), '{mts_pkg::OP_POP, '0, 1, 0, 1,
                                 res(VAL_MAX, VAL_MAX, 1, 0, mts_pkg::STS_OK)});
      rows.insert(rows.size(), '{mts_pkg::OP_POP, '0, 1, 0, 1,
                                 res('0, '0, 0, 1, mts_pkg::STS_OK)});
      rows.insert(rows.size(), '{mts_pkg::OP_POP, VAL_MAX, 1, 0, 1,
                                 res('0, '0, 0, 1, mts_pkg::STS_POP_EMPTY)});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, -32'sd1, 1, 0, 1,
                                 res(-32'sd1, -32'sd1, 1, 0, mts_pkg::STS_OK)});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, 32'sd1, 1, 0, 1,
                                 res(32'sd1, -32'sd1, 2, 0, mts_pkg::STS_OK)});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, -32'sd1, 1, 0, 0, '0});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, -32'sd5, 1, 0, 0, '0});
      rows.insert(rows.size(), '{mts_pkg::OP_POP, '0, 2, 0, 0, '0});
      // fill to the brim, then pushes against a full stack
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, '0, mts_pkg::STACK_DEPTH - 2, 1, 0, '0});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, '0, 1, 1, 0, '0});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, VAL_MAX, 1, 0, 0, '0});
      rows.insert(rows.size(), '{mts_pkg::OP_POP, '0, 1, 0, 0, '0});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, VAL_MIN, 1, 0, 0, '0});
      rows.insert(rows.size(), '{mts_pkg::OP_PUSH, '0, 1, 0, 0, '0});
      rows.insert(rows.size(), '{mts_pkg::OP_POP, '0, mts_pkg::STACK_DEPTH, 1, 0, '0});
      rows.insert(rows.size(), '{mts_pkg::OP_POP, '0, 1, 0, 1,
                                 res('0, '0, 0, 1, mts_pkg::STS_POP_EMPTY)});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         for (int k = 0; k < rows[i].reps; k++)
            send_item(rows[i].op, rows[i].rand_value ? $signed($urandom) : rows[i].value,
                      rows[i].fixed, rows[i].want);
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(40, 200);
         push_pct  = push_mix[$urandom_range(0, 4)];
         // hold off until the stack has answered everything in flight
         if (phase == 3 || $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (expected_results.size() != 0) @(posedge clock);
         end
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            op = ($urandom_range(0, 99) < push_pct) ? mts_pkg::OP_PUSH : mts_pkg::OP_POP;
            send_item(op, draw_push_value(), 1'b0, '0);
            sent++;
         end
         phase++;
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
